/* design/tphc_pkg.sv */
`default_nettype none
package tphc_pkg;

    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 32;
    localparam int HUM_W    = 29;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam int DIV_WN   = 34;
    localparam int DIV_BPS  = 2;
    localparam int DIV_STG  = DIV_WN / DIV_BPS;
    localparam int T_DEN_W  = 20;
    localparam int H_DEN_W  = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_P0_DEG = 4'd0,
        REG_TEMP_P1_DEG = 4'd1,
        REG_TEMP_P0_RAW = 4'd2,
        REG_TEMP_P1_RAW = 4'd3,
        REG_HUM_P0_PCT  = 4'd4,
        REG_HUM_P1_PCT  = 4'd5,
        REG_HUM_P0_RAW  = 4'd6,
        REG_HUM_P1_RAW  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic sgn_t;
        logic sgn_h;
        logic zero_t;
        logic zero_h;
    } t_side;

endpackage
`default_nettype wire

/* design/tphc_div.sv */
`default_nettype none
module tphc_div
    import tphc_pkg::*;
#(
    parameter int WN  = DIV_WN,
    parameter int WD  = T_DEN_W,
    parameter int BPS = DIV_BPS
) (
    input  wire logic                i_clk,
    input  wire logic [WN/BPS-1:0]   i_adv,
    input  wire logic [WN-1:0]       i_num,
    input  wire logic [WD-1:0]       i_den,
    output logic      [WN-1:0]       o_quo
);

    localparam int NSTG = WN / BPS;

    logic [WD-1:0] r_rem [NSTG];
    logic [WN-1:0] r_dq  [NSTG];
    logic [WD-1:0] r_den [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [WD-1:0] rem_in;
        logic [WD-1:0] den_in;
        logic [WN-1:0] dq_in;
        logic [WD-1:0] n_rem;
        logic [WN-1:0] n_dq;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign dq_in  = r_dq[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin : l_step
            logic [WD:0] v_t;
            v_t   = '0;
            n_rem = rem_in;
            n_dq  = dq_in;
            for (int j = 0; j < BPS; j++) begin
                v_t  = {n_rem, n_dq[WN-1]};
                n_dq = {n_dq[WN-2:0], 1'b0};
                if (v_t >= {1'b0, den_in}) begin
                    v_t     = v_t - {1'b0, den_in};
                    n_dq[0] = 1'b1;
                end
                n_rem = v_t[WD-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[s]) begin
                r_rem[s] <= n_rem;
                r_dq[s]  <= n_dq;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_dq[NSTG-1];

endmodule
`default_nettype wire

/* design/two_point_humidity_temp_calibration.sv */
// Two-point linear calibration of a raw temperature/humidity pair into 0.01 degC and
// 0.1 %rH, truncating toward zero; a channel whose raw points are equal reads 0 and sets
// its bit in tuser. Fully pipelined: one beat per cycle unless the output stalls;
// the 17-stage radix-4 restoring divider sits behind four stages of subtract, multiply,
// scale and magnitude. Bubbles collapse, so input is taken while a finished result waits.
// Configuration writes are taken every cycle and must be made with the pipeline empty.
`default_nettype none
module two_point_humidity_temp_calibration
    import tphc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [15:0] raw_temperature, [31:16] raw_humidity
    input  wire logic [31:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] temperature_centi_c, [60:32] humidity_deci_pct, [63:61] zero
    output logic [63:0]               m_axis_tdata,
    // [1:0] calib_status
    output logic [STAT_W-1:0]         m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int S_IN  = 0;
    localparam int S_MUL = 1;
    localparam int S_SCL = 2;
    localparam int S_ABS = 3;
    localparam int S_DIV = 4;
    localparam int S_OUT = S_DIV + DIV_STG;
    localparam int NS    = S_OUT + 1;

    logic [9:0]        r_tp0, r_tp1;
    logic signed [15:0] r_tr0, r_tr1;
    logic [7:0]        r_hp0, r_hp1;
    logic signed [15:0] r_hr0, r_hr1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp0 <= '0;
            r_tp1 <= '0;
            r_tr0 <= '0;
            r_tr1 <= '0;
            r_hp0 <= '0;
            r_hp1 <= '0;
            r_hr0 <= '0;
            r_hr1 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP_P0_DEG: r_tp0 <= i_cfg_data[9:0];
                REG_TEMP_P1_DEG: r_tp1 <= i_cfg_data[9:0];
                REG_TEMP_P0_RAW: r_tr0 <= i_cfg_data;
                REG_TEMP_P1_RAW: r_tr1 <= i_cfg_data;
                REG_HUM_P0_PCT:  r_hp0 <= i_cfg_data[7:0];
                REG_HUM_P1_PCT:  r_hp1 <= i_cfg_data[7:0];
                REG_HUM_P0_RAW:  r_hr0 <= i_cfg_data;
                REG_HUM_P1_RAW:  r_hr1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[S_IN]) begin
                r_vld[S_IN] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = rdy[S_IN];

    // differences
    logic signed [15:0] x_t, x_h;
    logic signed [16:0] r0_dxt, r0_dt, r0_dxh, r0_dh;
    logic signed [10:0] r0_pdt;
    logic signed [8:0]  r0_pdh;

    assign x_t = s_axis_tdata[15:0];
    assign x_h = s_axis_tdata[31:16];

    always_ff @(posedge i_clk) begin
        if (rdy[S_IN]) begin
            r0_dxt <= {x_t[15], x_t} - {r_tr0[15], r_tr0};
            r0_dt  <= {r_tr1[15], r_tr1} - {r_tr0[15], r_tr0};
            r0_pdt <= $signed({1'b0, r_tp1}) - $signed({1'b0, r_tp0});
            r0_dxh <= {x_h[15], x_h} - {r_hr0[15], r_hr0};
            r0_dh  <= {r_hr1[15], r_hr1} - {r_hr0[15], r_hr0};
            r0_pdh <= $signed({1'b0, r_hp1}) - $signed({1'b0, r_hp0});
        end
    end

    // products
    logic signed [10:0] tp0_s;
    logic signed [8:0]  hp0_s;
    logic signed [27:0] r1_at, r1_bt;
    logic signed [25:0] r1_ah, r1_bh;
    logic signed [16:0] r1_dt, r1_dh;

    assign tp0_s = $signed({1'b0, r_tp0});
    assign hp0_s = $signed({1'b0, r_hp0});

    always_ff @(posedge i_clk) begin
        if (rdy[S_MUL]) begin
            r1_at <= tp0_s * r0_dt;
            r1_bt <= r0_pdt * r0_dxt;
            r1_ah <= hp0_s * r0_dh;
            r1_bh <= r0_pdh * r0_dxh;
            r1_dt <= r0_dt;
            r1_dh <= r0_dh;
        end
    end

    // sum and scale
    logic signed [34:0] nt_w;
    logic signed [29:0] nh_w;
    logic signed [34:0] r2_nt;
    logic signed [29:0] r2_nh;
    logic signed [T_DEN_W-1:0] r2_dent;
    logic signed [H_DEN_W-1:0] r2_denh;

    assign nt_w = 35'(r1_at) + 35'(r1_bt);
    assign nh_w = 30'(r1_ah) + 30'(r1_bh);

    always_ff @(posedge i_clk) begin
        if (rdy[S_SCL]) begin
            r2_nt   <= (nt_w <<< 6) + (nt_w <<< 5) + (nt_w <<< 2);
            r2_nh   <= (nh_w <<< 3) + (nh_w <<< 1);
            r2_dent <= {r1_dt, 3'b000};
            r2_denh <= {r1_dh, 1'b0};
        end
    end

    // magnitudes and sign
    logic [34:0]        nt_neg;
    logic [29:0]        nh_neg;
    logic [T_DEN_W-1:0] dt_neg;
    logic [H_DEN_W-1:0] dh_neg;
    logic [DIV_WN-1:0]  r3_nt, r3_nh;
    logic [T_DEN_W-1:0] r3_dt;
    logic [H_DEN_W-1:0] r3_dh;
    t_side              r_sd [S_ABS:S_OUT-1];

    assign nt_neg = -r2_nt;
    assign nh_neg = -r2_nh;
    assign dt_neg = -r2_dent;
    assign dh_neg = -r2_denh;

    always_ff @(posedge i_clk) begin
        if (rdy[S_ABS]) begin
            r3_nt <= r2_nt[34] ? nt_neg[DIV_WN-1:0] : r2_nt[DIV_WN-1:0];
            r3_nh <= {5'b0, (r2_nh[29] ? nh_neg[28:0] : r2_nh[28:0])};
            r3_dt <= r2_dent[T_DEN_W-1] ? dt_neg : r2_dent;
            r3_dh <= r2_denh[H_DEN_W-1] ? dh_neg : r2_denh;
            r_sd[S_ABS] <= '{
                sgn_t:  r2_nt[34] ^ r2_dent[T_DEN_W-1],
                sgn_h:  r2_nh[29] ^ r2_denh[H_DEN_W-1],
                zero_t: (r2_dent == '0),
                zero_h: (r2_denh == '0)
            };
        end
        for (int k = S_DIV; k < S_OUT; k++) begin
            if (rdy[k]) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    logic [DIV_WN-1:0] qt, qh;

    tphc_div #(
        .WN  (DIV_WN),
        .WD  (T_DEN_W),
        .BPS (DIV_BPS)
    ) u_div_t (
        .i_clk (i_clk),
        .i_adv (rdy[S_OUT-1:S_DIV]),
        .i_num (r3_nt),
        .i_den (r3_dt),
        .o_quo (qt)
    );

    tphc_div #(
        .WN  (DIV_WN),
        .WD  (H_DEN_W),
        .BPS (DIV_BPS)
    ) u_div_h (
        .i_clk (i_clk),
        .i_adv (rdy[S_OUT-1:S_DIV]),
        .i_num (r3_nh),
        .i_den (r3_dh),
        .o_quo (qh)
    );

    // sign, zero divisor, output register
    logic [DIV_WN-1:0] qt_s, qh_s;
    logic [TEMP_W-1:0] r_temp;
    logic [HUM_W-1:0]  r_hum;
    logic [STAT_W-1:0] r_stat;
    t_side             sd_l;

    assign sd_l = r_sd[S_OUT-1];
    assign qt_s = sd_l.sgn_t ? -qt : qt;
    assign qh_s = sd_l.sgn_h ? -qh : qh;

    always_ff @(posedge i_clk) begin
        if (rdy[S_OUT]) begin
            r_temp <= sd_l.zero_t ? '0 : qt_s[TEMP_W-1:0];
            r_hum  <= sd_l.zero_h ? '0 : qh_s[HUM_W-1:0];
            r_stat <= {sd_l.zero_h, sd_l.zero_t};
        end
    end

    assign m_axis_tvalid = r_vld[S_OUT];
    assign m_axis_tdata  = {3'b000, r_hum, r_temp};
    assign m_axis_tuser  = r_stat;

endmodule
`default_nettype wire

/* design/tphc_checker.sv */
`default_nettype none
module tphc_checker
    import tphc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [63:0]          m_axis_tdata,
    input wire logic [STAT_W-1:0]    m_axis_tuser,
    input wire logic                 o_cfg_ready
);

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("temperature not zero with equal points");

    a_hum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[60:32] == 29'd0)
        else $error("humidity not zero with equal points");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind two_point_humidity_temp_calibration tphc_checker u_tphc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .o_cfg_ready   (o_cfg_ready)
);
`default_nettype wire

/* sim/tb_two_point_humidity_temp_calibration.sv */
`default_nettype none
module tb_two_point_humidity_temp_calibration;
    import tphc_pkg::*;

    localparam int LATENCY     = 22;
    localparam int WDOG_MAX    = 20000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HUM_W-1:0]  hum;
        logic [TEMP_W-1:0] temp;
    } t_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    two_point_humidity_temp_calibration dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [9:0]  t_deg0, t_deg1;
    logic [15:0] t_raw0, t_raw1;
    logic [7:0]  h_pct0, h_pct1;
    logic [15:0] h_raw0, h_raw1;

    t_reading expected_readings[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_status;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_off;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint line_value(longint p0, longint p1, longint r0, longint r1,
                                          longint x, longint scale, longint unit_div);
        longint d;
        longint y;
        d = r1 - r0;
        y = (p0 * d + (p1 - p0) * (x - r0)) * scale;
        return y / (d * unit_div);
    endfunction

    function automatic t_reading calibrate(logic [15:0] rt, logic [15:0] rh);
        t_reading r;
        longint v;
        r = '0;
        if (t_raw0 == t_raw1) begin
            r.status[0] = 1'b1;
        end else begin
            v = line_value(longint'(t_deg0), longint'(t_deg1), longint'($signed(t_raw0)),
                           longint'($signed(t_raw1)), longint'($signed(rt)), 100, 8);
            r.temp = v[TEMP_W-1:0];
        end
        if (h_raw0 == h_raw1) begin
            r.status[1] = 1'b1;
        end else begin
            v = line_value(longint'(h_pct0), longint'(h_pct1), longint'($signed(h_raw0)),
                           longint'($signed(h_raw1)), longint'($signed(rh)), 10, 2);
            r.hum = v[HUM_W-1:0];
        end
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TEMP_P0_DEG: t_deg0 = value[9:0];
            REG_TEMP_P1_DEG: t_deg1 = value[9:0];
            REG_TEMP_P0_RAW: t_raw0 = value;
            REG_TEMP_P1_RAW: t_raw1 = value;
            REG_HUM_P0_PCT:  h_pct0 = value[7:0];
            REG_HUM_P1_PCT:  h_pct1 = value[7:0];
            REG_HUM_P0_RAW:  h_raw0 = value;
            REG_HUM_P1_RAW:  h_raw1 = value;
            default: ;
        endcase
    endtask

    task automatic load_points(logic [9:0] td0, logic [9:0] td1, logic [15:0] tr0,
                               logic [15:0] tr1, logic [7:0] hp0, logic [7:0] hp1,
                               logic [15:0] hr0, logic [15:0] hr1);
        write_reg(REG_TEMP_P0_DEG, {6'd0, td0});
        write_reg(REG_TEMP_P1_DEG, {6'd0, td1});
        write_reg(REG_TEMP_P0_RAW, tr0);
        write_reg(REG_TEMP_P1_RAW, tr1);
        write_reg(REG_HUM_P0_PCT, {8'd0, hp0});
        write_reg(REG_HUM_P1_PCT, {8'd0, hp1});
        write_reg(REG_HUM_P0_RAW, hr0);
        write_reg(REG_HUM_P1_RAW, hr1);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] rt, logic [15:0] rh);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rh, rt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_readings.push_back(calibrate(rt, rh));
        n_sent++;
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_points();
        logic [15:0] tr0, hr0;
        tr0 = pick_raw();
        hr0 = pick_raw();
        load_points(10'($urandom), 10'($urandom), tr0,
                    ($urandom_range(9) == 0) ? tr0 : pick_raw(),
                    8'($urandom), 8'($urandom), hr0,
                    ($urandom_range(9) == 0) ? hr0 : pick_raw());
    endtask

    task automatic test_directed();
        load_points(10'd200, 10'd600, 16'hf000, 16'h1000, 8'd40, 8'd160, 16'h0100, 16'h2000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'hf000, 16'h0100);
        send_sample(16'h1000, 16'h2000);
        send_sample(16'hffff, 16'h0001);
        send_sample(16'h5555, 16'haaaa);
        drain();
        load_points(10'h3ff, 10'd0, 16'h8000, 16'h7fff, 8'hff, 8'd0, 16'h7fff, 16'h8000);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'haaaa, 16'h5555);
        send_sample(16'h0001, 16'hffff);
        drain();
        load_points(10'd0, 10'h3ff, 16'h0000, 16'h0001, 8'd0, 8'hff, 16'hffff, 16'h0000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h0003, 16'hfffd);
        drain();
        load_points(10'd100, 10'd300, 16'h1234, 16'h1234, 8'd50, 8'd90, 16'h0400, 16'h0800);
        send_sample(16'h1234, 16'h0600);
        send_sample(16'h8000, 16'h7fff);
        drain();
        load_points(10'd100, 10'd300, 16'h0400, 16'h0800, 8'd50, 8'd90, 16'h8000, 16'h8000);
        send_sample(16'h0600, 16'h8000);
        drain();
        load_points(10'd0, 10'd0, 16'h0000, 16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h0000, 16'h0000);
        drain();
    endtask

    task automatic test_random(int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                drain();
                random_points();
            end
            send_sample(pick_raw(), pick_raw());
        end
        drain();
    endtask

    task automatic test_backpressure();
        int i;
        random_points();
        send_idle_pct = 0;
        hold_req++;
        for (i = 0; i < 60; i++) send_sample(16'($urandom), 16'($urandom));
        drain();
        for (i = 0; i < 10; i++) send_sample(pick_raw(), pick_raw());
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_off <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_off <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected beat: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                n_checked++;
                if (want.status != 0) n_status++;
                if (m_axis_tdata[31:0] !== want.temp) begin
                    $error("temperature_centi_c: expected %0d, got %0d",
                           $signed(want.temp), $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[60:32] !== want.hum) begin
                    $error("humidity_deci_pct: expected %0d, got %0d",
                           $signed(want.hum), $signed(m_axis_tdata[60:32]));
                    errors++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("calib_status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("tb_two_point_humidity_temp_calibration: done, errors");
                $finish;
            end
        end
    end

    initial begin
        n_sent = 0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        t_deg0 = '0; t_deg1 = '0; t_raw0 = '0; t_raw1 = '0;
        h_pct0 = '0; h_pct1 = '0; h_raw0 = '0; h_raw1 = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 36;
        recv_idle_pct = 53;
        test_directed();
        test_random(480);
        send_idle_pct = 53;
        recv_idle_pct = 36;
        test_random(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(420);
        test_backpressure();
        $display("covered %0d samples over many calibration sets, %0d checked,", n_sent,
                 n_checked);
        $display("%0d with equal raw points, under idling, stalls and a long hold-off", n_status);
        if (errors == 0) begin
            $display("tb_two_point_humidity_temp_calibration: done, clean");
        end else begin
            $display("tb_two_point_humidity_temp_calibration: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* two_point_humidity_temp_calibration.f */
design/tphc_pkg.sv
design/tphc_div.sv
design/two_point_humidity_temp_calibration.sv
design/tphc_checker.sv
sim/tb_two_point_humidity_temp_calibration.sv
